>>> rtl/cga_pkg.sv
// Shared types, constants and helper functions of the compact genetic search engine.
package cga_pkg;

  localparam int MAX_GENES = 32;
  localparam int PROB_BITS = 16;
  localparam int PW        = PROB_BITS + 1;
  localparam int CAND_BITS = 32;
  localparam int LFSR_W    = 16;
  localparam int GENES_W   = 6;
  localparam int CFG_W     = 16;
  localparam int COST_W    = 32;
  localparam int ITER_W    = 16;

  typedef logic [PW-1:0]      prob_t;
  typedef logic [LFSR_W-1:0]  lfsr_t;
  typedef logic [GENES_W-1:0] lane_t;

  localparam prob_t PROB_ONE  = prob_t'(1) << PROB_BITS;
  localparam prob_t PROB_HALF = prob_t'(1) << (PROB_BITS - 1);
  localparam lfsr_t LFSR_MASK = 16'hB400;

  // Operation codes.
  localparam logic OP_RESTART  = 1'b0;
  localparam logic OP_EVALUATE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_STEP  = 2'd0;
  localparam logic [1:0] REG_LIMIT = 2'd1;
  localparam logic [1:0] REG_GENES = 2'd2;
  localparam logic [1:0] REG_SEED  = 2'd3;

  // Configuration reset values.
  localparam logic [CFG_W-1:0]   RESET_STEP  = 16'd655;
  localparam logic [ITER_W-1:0]  RESET_LIMIT = 16'd1000;
  localparam logic [GENES_W-1:0] RESET_GENES = 6'd32;
  localparam lfsr_t              RESET_SEED  = 16'd44257;

  typedef enum logic [1:0] {
    ST_PAIR      = 2'd0,
    ST_CONVERGED = 2'd1,
    ST_LIMIT     = 2'd2,
    ST_IGNORED   = 2'd3
  } cga_status_t;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] cost_first;
    logic signed [31:0] cost_second;
  } cga_in_t;

  typedef struct packed {
    logic [31:0] candidate_a;
    logic [31:0] candidate_b;
    cga_status_t status;
    logic [15:0] iterations;
  } cga_out_t;

  // Control broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic  load;    // restart: reload generators, probabilities to one half
    logic  update;  // tournament: move probabilities toward the winner
    prob_t delta;   // step in probability scale
    lfsr_t seed;
  } cga_ctrl_t;

  // Scales a 16-bit fraction to the probability scale.
  function automatic prob_t prob_scale(input lfsr_t x);
    logic [LFSR_W+PROB_BITS-1:0] wide;
    begin
      wide = {x, {PROB_BITS{1'b0}}};
      return prob_t'(wide[LFSR_W+PROB_BITS-1:LFSR_W]);
    end
  endfunction

  // One step of the Galois LFSR with taps 16, 14, 13 and 11.
  function automatic lfsr_t lfsr_advance(input lfsr_t s);
    begin
      return s[0] ? ((s >> 1) ^ LFSR_MASK) : (s >> 1);
    end
  endfunction

endpackage

>>> rtl/cga_cell.sv
// One gene lane: probability, lane generator, tournament update and sampling.
module cga_cell (
  input  logic               clk,
  input  logic               rst,
  input  cga_pkg::cga_ctrl_t ctrl,
  input  cga_pkg::lane_t     lane,
  input  logic               active,
  input  logic               win_bit,
  input  logic               lose_bit,
  input  logic               finish,
  input  logic               conv_in,
  output logic               conv_out,
  output logic               bit_a,
  output logic               bit_b
);
  import cga_pkg::*;

  prob_t prob;
  lfsr_t lfsr;

  prob_t moved;
  prob_t p_upd;
  logic [PW:0] sum;
  logic [PW:0] conv_sum;
  logic lane_conv;
  lfsr_t loaded;
  lfsr_t base;
  lfsr_t s1;
  lfsr_t s2;

  always_comb begin
    sum   = {1'b0, prob} + {1'b0, ctrl.delta};
    moved = prob;
    if (active && win_bit && !lose_bit) begin
      moved = (sum > {1'b0, PROB_ONE}) ? PROB_ONE : sum[PW-1:0];
    end else if (active && !win_bit && lose_bit) begin
      moved = (prob > ctrl.delta) ? (prob - ctrl.delta) : '0;
    end
    p_upd = ctrl.load ? PROB_HALF : moved;
  end

  // A lane has converged when it sits within one step of either end.
  always_comb begin
    conv_sum  = {1'b0, p_upd} + {1'b0, ctrl.delta};
    lane_conv = (conv_sum >= {1'b0, PROB_ONE}) || (p_upd <= ctrl.delta);
    conv_out  = conv_in & (!active | lane_conv);
  end

  always_comb begin
    loaded = ctrl.seed ^ lfsr_t'(lane);
    if (loaded == '0) begin
      loaded = lfsr_t'(1);
    end
    base  = ctrl.load ? loaded : lfsr;
    s1    = lfsr_advance(base);
    s2    = lfsr_advance(s1);
    bit_a = active && (prob_scale(s1) < p_upd);
    bit_b = active && (prob_scale(s2) < p_upd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prob <= PROB_HALF;
      lfsr <= RESET_SEED ^ lfsr_t'(lane);
    end else if (ctrl.load || ctrl.update) begin
      prob <= p_upd;
      if (active) begin
        lfsr <= finish ? s1 : s2;
      end else begin
        lfsr <= base;
      end
    end
  end

endmodule

>>> rtl/compact_genetic_search.sv
// Top level of the compact genetic search engine: sequencer and a row of gene cells.
// A result item is registered once its item leaves the first stage, which waits while a result stalls.
// Throughput: one item per cycle, back to back; while a result stalls one more item waits.
// The cost compare is registered in the first stage; the cells and result register update when it moves on.
// Reset (rst, synchronous): registers take their reset values, every probability is one half,
// generators hold seed xor lane, and the search is not running.
module compact_genetic_search (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  cga_pkg::cga_in_t    req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output cga_pkg::cga_out_t   rsp,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import cga_pkg::*;

  // Configuration registers.
  logic [CFG_W-1:0]   step;
  logic [ITER_W-1:0]  iteration_limit;
  logic [GENES_W-1:0] genes_in_use;
  lfsr_t              random_seed;

  // Search state held outside the cells.
  logic [CAND_BITS-1:0] held_a;
  logic [CAND_BITS-1:0] held_b;
  logic [ITER_W-1:0]    iteration_count;
  logic                 running;

  // First stage: the item with its cost comparison already resolved.
  logic s1_valid;
  logic s1_op;
  logic s1_first_wins;

  logic adv;
  logic is_restart;
  logic finish;
  logic conv_all;
  logic [ITER_W-1:0] count_new;
  logic [CAND_BITS-1:0] win;
  logic [CAND_BITS-1:0] lose;
  logic [CAND_BITS-1:0] draw_a;
  logic [CAND_BITS-1:0] draw_b;
  logic [MAX_GENES:0]   conv;
  logic [MAX_GENES-1:0] lane_bit_a;
  logic [MAX_GENES-1:0] lane_bit_b;
  logic [MAX_GENES-1:0] lane_win;
  logic [MAX_GENES-1:0] lane_lose;
  logic [MAX_GENES-1:0] lane_active;
  cga_ctrl_t ctrl;
  cga_out_t  result;

  // Configuration writes are taken at any time; the user writes only while idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step            <= RESET_STEP;
      iteration_limit <= RESET_LIMIT;
      genes_in_use    <= RESET_GENES;
      random_seed     <= RESET_SEED;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STEP:  step            <= cfg_data;
        REG_LIMIT: iteration_limit <= cfg_data;
        REG_GENES: genes_in_use    <= cfg_data[GENES_W-1:0];
        REG_SEED:  random_seed     <= cfg_data;
        default: ;
      endcase
    end
  end

  // The first stage moves on whenever the result register is free or being emptied,
  // so while a result stalls one more item can be taken and wait in the first stage.
  assign adv       = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  // The signed compare depends only on the item, so it is done ahead of the cells.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_op         <= req.operation;
      s1_first_wins <= $signed(req.cost_first) < $signed(req.cost_second);
    end
  end

  assign is_restart = (s1_op == OP_RESTART);

  always_comb begin
    ctrl.load   = adv && is_restart;
    ctrl.update = adv && !is_restart && running;
    ctrl.delta  = prob_scale(step);
    ctrl.seed   = random_seed;
  end

  // A tie makes the second candidate the winner.
  assign win  = s1_first_wins ? held_a : held_b;
  assign lose = s1_first_wins ? held_b : held_a;

  assign conv[0]  = 1'b1;
  assign conv_all = conv[MAX_GENES];

  genvar i;
  generate
    for (i = 0; i < MAX_GENES; i++) begin : g_lane
      assign lane_active[i] = genes_in_use > GENES_W'(i);
      if (i < CAND_BITS) begin : g_bits
        assign lane_win[i]  = win[i];
        assign lane_lose[i] = lose[i];
      end else begin : g_nobits
        assign lane_win[i]  = 1'b0;
        assign lane_lose[i] = 1'b0;
      end
      cga_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .lane     (GENES_W'(i)),
        .active   (lane_active[i]),
        .win_bit  (lane_win[i]),
        .lose_bit (lane_lose[i]),
        .finish   (finish),
        .conv_in  (conv[i]),
        .conv_out (conv[i+1]),
        .bit_a    (lane_bit_a[i]),
        .bit_b    (lane_bit_b[i])
      );
    end
    for (i = 0; i < CAND_BITS; i++) begin : g_draw
      if (i < MAX_GENES) begin : g_used
        assign draw_a[i] = lane_bit_a[i];
        assign draw_b[i] = lane_bit_b[i];
      end else begin : g_empty
        assign draw_a[i] = 1'b0;
        assign draw_b[i] = 1'b0;
      end
    end
  endgenerate

  // The count saturates at its top value.
  assign count_new = (iteration_count == '1) ? iteration_count : iteration_count + 1'b1;

  // Convergence wins over the limit when a tournament reaches both.
  always_comb begin
    if (is_restart) begin
      finish = (iteration_limit == '0);
    end else begin
      finish = conv_all || (count_new >= iteration_limit);
    end
  end

  always_comb begin
    result.candidate_a = draw_a;
    result.candidate_b = finish ? '0 : draw_b;
    result.iterations  = iteration_count;
    result.status      = ST_PAIR;
    if (is_restart) begin
      result.iterations = '0;
      result.status     = finish ? ST_LIMIT : ST_PAIR;
    end else if (running) begin
      result.iterations = count_new;
      if (conv_all) begin
        result.status = ST_CONVERGED;
      end else if (finish) begin
        result.status = ST_LIMIT;
      end
    end else begin
      // An evaluate while idle changes nothing and reports that it was ignored.
      result.candidate_a = '0;
      result.candidate_b = '0;
      result.status      = ST_IGNORED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_a          <= '0;
      held_b          <= '0;
      iteration_count <= '0;
      running         <= 1'b0;
    end else if (ctrl.load || ctrl.update) begin
      held_a          <= result.candidate_a;
      held_b          <= result.candidate_b;
      iteration_count <= result.iterations;
      running         <= !finish;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp <= result;
    end
  end

endmodule

>>> rtl/cga_checker.sv
// Port-level checks of the compact genetic search engine and their binding.
module cga_checker (
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input cga_pkg::cga_out_t rsp
);
  import cga_pkg::*;

  // A result waiting on the consumer is not dropped.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result item withdrawn before it was taken");

  // A finished search shows no second candidate.
  a_finish_b_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_CONVERGED || rsp.status == ST_LIMIT)
      |-> rsp.candidate_b == '0)
    else $error("second candidate not zero on a finished search");

  // An ignored evaluate shows no candidates at all.
  a_ignored_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_IGNORED
      |-> rsp.candidate_a == '0 && rsp.candidate_b == '0)
    else $error("candidates not zero on an ignored evaluate");

  // No result can appear right after reset, since no item has been accepted.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result item valid right after reset");

endmodule

bind compact_genetic_search cga_checker u_cga_checker (.*);
